@@ src/ip_address_text_classifier_unit_defines.svh @@
// Assertion macros for the address text classifier.
// Taken in by the top level only; no other dependencies.
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_UNIT_DEFINES_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define IATC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("iatc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define IATC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("iatc: next-cycle check failed");

`endif

@@ src/iatc_pkg.sv @@
// Shared types, constants and helper functions for the address text classifier.
// No dependencies; used by every module of the block.
package iatc_pkg;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	localparam logic [9:0] DEC_MAX_VALUE  = 10'd255;
	localparam logic [2:0] DEC_MAX_DIGITS = 3'd3;
	localparam logic [2:0] HEX_MAX_DIGITS = 3'd4;
	localparam logic [2:0] DOTS_NEEDED    = 3'd3;
	localparam logic [3:0] COLONS_NEEDED  = 4'd7;
	localparam logic [2:0] LEN_SAT        = 3'd7;
	localparam logic [2:0] DOT_SAT        = 3'd7;
	localparam logic [3:0] COLON_SAT      = 4'd15;

	typedef enum logic [1:0] {
		CLASS_V4   = 2'd0,
		CLASS_V6   = 2'd1,
		CLASS_NONE = 2'd2
	} addr_class_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
		logic       empty_req;
	} item_t;

	typedef struct packed {
		logic [2:0] dot_count;
		logic [3:0] colon_count;
		logic [2:0] dec_group_length;
		logic [9:0] dec_group_value;
		logic       dec_leading_zero;
		logic       dec_ok;
		logic [2:0] hex_group_length;
		logic       hex_ok;
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '{
		dot_count:        3'd0,
		colon_count:      4'd0,
		dec_group_length: 3'd0,
		dec_group_value:  10'd0,
		dec_leading_zero: 1'b0,
		dec_ok:           1'b1,
		hex_group_length: 3'd0,
		hex_ok:           1'b1
	};

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
			((c >= 8'h41) && (c <= 8'h46));
	endfunction

	// Check the open decimal group, then clear it.
	function automatic scan_state_t close_dec(input scan_state_t s);
		scan_state_t r;
		r = s;
		if ((s.dec_group_length == 3'd0) || (s.dec_group_length > DEC_MAX_DIGITS))
			r.dec_ok = 1'b0;
		if (s.dec_leading_zero && (s.dec_group_length > 3'd1))
			r.dec_ok = 1'b0;
		if (s.dec_group_value > DEC_MAX_VALUE)
			r.dec_ok = 1'b0;
		r.dec_group_length = 3'd0;
		r.dec_group_value  = 10'd0;
		r.dec_leading_zero = 1'b0;
		return r;
	endfunction

	// Check the open hex group, then clear it.
	function automatic scan_state_t close_hex(input scan_state_t s);
		scan_state_t r;
		r = s;
		if ((s.hex_group_length == 3'd0) || (s.hex_group_length > HEX_MAX_DIGITS))
			r.hex_ok = 1'b0;
		r.hex_group_length = 3'd0;
		return r;
	endfunction

endpackage

@@ src/iatc_in_if.sv @@
// Character channel: valid/ready handshake with one text byte and its flags.
// No dependencies.
interface iatc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	logic       empty_req;

	modport source (output valid, output character, output last, output empty_req,
		input ready);
	modport sink (input valid, input character, input last, input empty_req,
		output ready);
endinterface

@@ src/iatc_out_if.sv @@
// Result channel: valid/ready handshake carrying one address class.
// No dependencies.
interface iatc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] address_class;

	modport source (output valid, output address_class, input ready);
	modport sink (input valid, input address_class, output ready);
endinterface

@@ src/ip_address_text_classifier_unit.sv @@
// Channel  | Dir | Payload                          | Handshake
// text     | in  | character[7:0], last, empty_req  | valid/ready
// verdict  | out | address_class[1:0]               | valid/ready
//
// One character per cycle unless stalled; a final item loads the result register.
// The single scan register stage sets throughput: one update per unstalled clock.
// arst_n clears the input stage, the scan state and the result register.
// text.ready drops only when a final item waits in the input stage and the
// result register is full and not being taken.
// Depends on iatc_pkg, iatc_in_if, iatc_out_if, iatc_scan and the defines header.
`include "ip_address_text_classifier_unit_defines.svh"

module ip_address_text_classifier_unit (
	input  logic      clk,
	input  logic      arst_n,
	iatc_in_if.sink   text,
	iatc_out_if.source verdict
);

	iatc_pkg::item_t       item_s1;
	logic                  valid_s1;
	logic                  res_s1;
	logic                  adv_s1;
	logic                  out_free;
	iatc_pkg::addr_class_t cls;
	logic                  out_valid_q;
	iatc_pkg::addr_class_t out_class_q;

	assign res_s1   = item_s1.last || item_s1.empty_req;
	assign out_free = !out_valid_q || verdict.ready;
	assign adv_s1   = valid_s1 && (!res_s1 || out_free);

	assign text.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1 <= '{character: text.character, last: text.last,
				empty_req: text.empty_req};
		end
	end

	iatc_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.item    (item_s1),
		.verdict (cls)
	);

	// result register: load on a finishing item, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_s1)
			out_class_q <= cls;
	end

	assign verdict.valid         = out_valid_q;
	assign verdict.address_class = out_class_q;

	`IATC_ASSERT_NEXT(a_final_loads_result, clk, arst_n, adv_s1 && res_s1, out_valid_q)
	`IATC_ASSERT_NEXT(a_empty_gives_none, clk, arst_n, adv_s1 && item_s1.empty_req, out_class_q == iatc_pkg::CLASS_NONE)
	`IATC_ASSERT_IMP(a_stall_cause, clk, arst_n, !text.ready, valid_s1 && res_s1 && out_valid_q && !verdict.ready)

endmodule

@@ src/iatc_scan.sv @@
// Per-string scan state and its one-character update, plus the final verdict.
// Depends on iatc_pkg.
module iatc_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  iatc_pkg::item_t       item,
	output iatc_pkg::addr_class_t verdict
);

	iatc_pkg::scan_state_t st_q;
	iatc_pkg::scan_state_t st_upd;
	iatc_pkg::scan_state_t st_fin;
	iatc_pkg::scan_state_t st_nxt;
	logic [3:0]            digit;
	logic [9:0]            times_ten;

	assign digit     = item.character[3:0];
	assign times_ten = {st_q.dec_group_value[6:0], 3'b000} +
		{st_q.dec_group_value[8:0], 1'b0};

	always_comb begin
		st_upd = st_q;

		// decimal reading
		if (item.character == iatc_pkg::CH_DOT) begin
			if (st_q.dot_count != iatc_pkg::DOT_SAT)
				st_upd.dot_count = st_q.dot_count + 3'd1;
			st_upd = iatc_pkg::close_dec(st_upd);
		end else if (iatc_pkg::is_dec(item.character)) begin
			if ((st_q.dec_group_length == 3'd0) && (item.character == iatc_pkg::CH_ZERO))
				st_upd.dec_leading_zero = 1'b1;
			if (st_q.dec_group_length < iatc_pkg::DEC_MAX_DIGITS)
				st_upd.dec_group_value = times_ten + {6'd0, digit};
			else
				st_upd.dec_ok = 1'b0;
			if (st_q.dec_group_length != iatc_pkg::LEN_SAT)
				st_upd.dec_group_length = st_q.dec_group_length + 3'd1;
		end else begin
			st_upd.dec_ok = 1'b0;
		end

		// hex reading
		if (item.character == iatc_pkg::CH_COLON) begin
			if (st_q.colon_count != iatc_pkg::COLON_SAT)
				st_upd.colon_count = st_q.colon_count + 4'd1;
			st_upd = iatc_pkg::close_hex(st_upd);
		end else if (iatc_pkg::is_hex(item.character)) begin
			if (st_q.hex_group_length >= iatc_pkg::HEX_MAX_DIGITS)
				st_upd.hex_ok = 1'b0;
			if (st_q.hex_group_length != iatc_pkg::LEN_SAT)
				st_upd.hex_group_length = st_q.hex_group_length + 3'd1;
		end else begin
			st_upd.hex_ok = 1'b0;
		end
	end

	// Close both open groups at the end of the string and classify.
	always_comb begin
		st_fin = iatc_pkg::close_hex(iatc_pkg::close_dec(st_upd));
		if (item.empty_req)
			verdict = iatc_pkg::CLASS_NONE;
		else if (st_fin.dot_count == iatc_pkg::DOTS_NEEDED)
			verdict = st_fin.dec_ok ? iatc_pkg::CLASS_V4 : iatc_pkg::CLASS_NONE;
		else if (st_fin.colon_count == iatc_pkg::COLONS_NEEDED)
			verdict = st_fin.hex_ok ? iatc_pkg::CLASS_V6 : iatc_pkg::CLASS_NONE;
		else
			verdict = iatc_pkg::CLASS_NONE;
	end

	assign st_nxt = (item.last || item.empty_req) ? iatc_pkg::STATE_RESET : st_upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= iatc_pkg::STATE_RESET;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule
